FILE: design/prp_pkg.sv
// ----------------------------------------------------------------------------
// prp_pkg
// shared types and helpers of the polyline ribbon projector
// ----------------------------------------------------------------------------
`default_nettype none

package prp_pkg;

  localparam int RowW  = 63;   // packed matrix row register width
  localparam int OpW   = 25;   // projection operand width
  localparam int QuotW = 18;   // signed quotient width handed to the clip test
  localparam int CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ROW0   = 3'd0,
    REG_ROW1   = 3'd1,
    REG_ROW2   = 3'd2,
    REG_LEFT   = 3'd3,
    REG_TOP    = 3'd4,
    REG_RIGHT  = 3'd5,
    REG_BOTTOM = 3'd6
  } prp_reg_t;

  typedef struct packed {
    logic [2:0][RowW-1:0] row;
    logic signed [15:0]   left;
    logic signed [15:0]   top;
    logic signed [15:0]   right;
    logic signed [15:0]   bottom;
  } prp_cfg_t;

  // one classified point waiting for the back end
  typedef struct packed {
    logic signed [OpW-1:0] a;       // forward
    logic signed [OpW-1:0] b_left;  // lateral minus half-width
    logic signed [OpW-1:0] b_right; // lateral plus half-width
    logic signed [OpW-1:0] c;       // vertical plus offset
    logic                  mono;
    logic                  start;
    logic                  skip;    // behind the viewer
  } prp_job_t;

  typedef enum logic [3:0] {
    B_IDLE, B_MAC, B_ACC, B_DIVX, B_WAITX, B_DIVY, B_WAITY, B_CHK, B_OUT0, B_OUT1
  } prp_state_t;

  function automatic logic signed [15:0] sat16(input logic signed [QuotW-1:0] v);
    logic signed [15:0] r;
    if (v > QuotW'(32767)) r = 16'sh7fff;
    else if (v < -QuotW'(32768)) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/prp_in_if.sv
// ----------------------------------------------------------------------------
// prp_in_if
// point transaction channel
// ----------------------------------------------------------------------------
`default_nettype none

interface prp_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] point_x;
  logic signed [23:0] point_y;
  logic signed [23:0] point_z;
  logic [15:0]        half_width;
  logic signed [15:0] height_offset;
  logic               keep_monotone;
  logic               start_of_line;

  modport source (output valid, point_x, point_y, point_z, half_width, height_offset,
                  keep_monotone, start_of_line, input ready);
  modport sink (input valid, point_x, point_y, point_z, half_width, height_offset,
                keep_monotone, start_of_line, output ready);
endinterface

`default_nettype wire

FILE: design/prp_out_if.sv
// ----------------------------------------------------------------------------
// prp_out_if
// screen point transaction channel
// ----------------------------------------------------------------------------
`default_nettype none

interface prp_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] screen_x;
  logic signed [15:0] screen_y;
  logic               side;
  logic               last;

  modport source (output valid, screen_x, screen_y, side, last, input ready);
  modport sink (input valid, screen_x, screen_y, side, last, output ready);
endinterface

`default_nettype wire

FILE: design/polyline_ribbon_projector.sv
// ----------------------------------------------------------------------------
// polyline_ribbon_projector
// projects polyline points, offset to a ribbon, onto the screen with clipping
// ----------------------------------------------------------------------------
// Each accepted point transaction is turned into a left and a right copy
// (lateral position minus and plus the half-width, height plus the offset),
// each copy goes through the 3x3 projection matrix and is divided by its depth.
// When both copies land inside the inclusive clip rectangle, two result
// transactions follow: the left point (side 0) and then the right point (side 1,
// last set). A point with negative forward distance yields nothing, and so does
// a pair with a copy at nonpositive depth, a copy outside the clip rectangle,
// or, with keep_monotone set, a left point lower than the previous emitted one.
// start_of_line clears the polygon state first. A point behind the viewer is
// popped and dropped in the idle state; a projected point's time is set by
// the single shared multiplier (nine products per copy) and the serial divider
// (one run per quotient, up to four per point). A two-entry queue in front lets
// new points be taken while the back end works or a result waits. The user must
// write configuration only while the block is idle; not enforced by the block.
// ----------------------------------------------------------------------------
`default_nettype none

module polyline_ribbon_projector #(
  parameter int COEFF_BITS = 21
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  prp_in_if.sink                             in_ch,
  prp_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [prp_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [prp_pkg::RowW-1:0]      cfg_data
);
  import prp_pkg::*;

  prp_cfg_t cfg_r;
  prp_job_t push_job, head_job;
  logic     q_full, q_push, head_valid, pop;

  // configuration registers, writes to unused indexes fall through
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row    <= '0;
      cfg_r.left   <= 16'sh8000;
      cfg_r.top    <= 16'sh8000;
      cfg_r.right  <= 16'sh7fff;
      cfg_r.bottom <= 16'sh7fff;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW0:   cfg_r.row[0] <= cfg_data;
        REG_ROW1:   cfg_r.row[1] <= cfg_data;
        REG_ROW2:   cfg_r.row[2] <= cfg_data;
        REG_LEFT:   cfg_r.left   <= cfg_data[15:0];
        REG_TOP:    cfg_r.top    <= cfg_data[15:0];
        REG_RIGHT:  cfg_r.right  <= cfg_data[15:0];
        REG_BOTTOM: cfg_r.bottom <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // front: operand forming and classification
  prp_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (push_job)
  );

  // decoupling queue
  prp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // back: projection, divide, clip, monotone test and output register
  prp_back #(.COEFF_BITS(COEFF_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_ch     (out_ch)
  );
endmodule

`default_nettype wire

FILE: design/prp_front.sv
// ----------------------------------------------------------------------------
// prp_front
// accepts points, forms ribbon operands and flags points behind the viewer
// ----------------------------------------------------------------------------
`default_nettype none

module prp_front (
  prp_in_if.sink             in_ch,
  input  wire logic          q_full,
  output logic               q_push,
  output prp_pkg::prp_job_t  q_job
);
  import prp_pkg::*;

  logic signed [OpW-1:0] y_ext;
  logic signed [OpW-1:0] hw_ext;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  assign y_ext  = OpW'(in_ch.point_y);
  assign hw_ext = $signed({{(OpW-16){1'b0}}, in_ch.half_width});

  always_comb begin
    q_job.a       = OpW'(in_ch.point_x);
    q_job.b_left  = y_ext - hw_ext;
    q_job.b_right = y_ext + hw_ext;
    q_job.c       = OpW'(in_ch.point_z) + OpW'(in_ch.height_offset);
    q_job.mono    = in_ch.keep_monotone;
    q_job.start   = in_ch.start_of_line;
    q_job.skip    = in_ch.point_x[23];
  end
endmodule

`default_nettype wire

FILE: design/prp_queue.sv
// ----------------------------------------------------------------------------
// prp_queue
// two-entry queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module prp_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire prp_pkg::prp_job_t push_job,
  output logic                   full,
  input  wire logic              pop,
  output logic                   head_valid,
  output prp_pkg::prp_job_t      head_job
);
  import prp_pkg::*;

  prp_job_t   mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_job   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end
endmodule

`default_nettype wire

FILE: design/prp_div.sv
// ----------------------------------------------------------------------------
// prp_div
// serial restoring divider, (num * 16) / den toward zero, magnitude clamped
// ----------------------------------------------------------------------------
`default_nettype none

module prp_div #(
  parameter int NUM_W = 48
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic signed [NUM_W-1:0]  num,
  input  wire logic [NUM_W-1:0]         den,
  output logic                          done,
  output logic signed [prp_pkg::QuotW-1:0] quot
);
  import prp_pkg::*;

  localparam int RemW = NUM_W + 4;
  localparam int DivW = NUM_W + 20;

  logic [RemW-1:0] rem_r;
  logic [DivW-1:0] d_r;
  logic [16:0]     q_r;
  logic [4:0]      cnt_r;
  logic            busy_r, done_r, neg_r;
  logic [NUM_W-1:0] num_mag;
  logic            fits;

  assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign fits    = {16'd0, rem_r} >= d_r;

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {num_mag, 4'd0};
      d_r   <= {4'd0, den, 16'd0};
      neg_r <= num[NUM_W-1];
      cnt_r <= 5'd0;
    end else if (busy_r) begin
      if (fits) rem_r <= rem_r - d_r[RemW-1:0];
      q_r   <= {q_r[15:0], fits};
      d_r   <= d_r >> 1;
      cnt_r <= cnt_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == 5'd16);
      if (start) busy_r <= 1'b1;
      else if (cnt_r == 5'd16) busy_r <= 1'b0;
    end
  end

  // a set top bit means the magnitude reached 65536, beyond any clip edge
  always_comb begin
    if (q_r[16]) quot = neg_r ? -QuotW'(65536) : QuotW'(65536);
    else quot = neg_r ? -$signed({2'b00, q_r[15:0]}) : $signed({2'b00, q_r[15:0]});
  end

  assign done = done_r;
endmodule

`default_nettype wire

FILE: design/prp_back.sv
// ----------------------------------------------------------------------------
// prp_back
// matrix product, perspective divide, clip and monotone test, result output
// ----------------------------------------------------------------------------
`default_nettype none

module prp_back #(
  parameter int COEFF_BITS = 21
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire prp_pkg::prp_cfg_t cfg,
  input  wire logic              head_valid,
  input  wire prp_pkg::prp_job_t head_job,
  output logic                   pop,
  prp_out_if.source              out_ch
);
  import prp_pkg::*;

  localparam int ProdW = COEFF_BITS + OpW;
  localparam int AccW  = COEFF_BITS + OpW + 2;

  prp_state_t state_r, state_nxt;
  prp_job_t   job_r;
  logic [1:0] row_r, k_r, prow_r;
  logic       pend_r, copy_r, in_ok_r;
  logic signed [ProdW-1:0] prod_r;
  logic signed [AccW-1:0]  acc_r [3];
  logic signed [QuotW-1:0] qx_r;
  logic signed [15:0] lx_r, ly_r, rx_r, ry_r, prev_y_r;
  logic        nonempty_r;
  logic signed [15:0] ox_r, oy_r;
  logic        oside_r, ovalid_r;

  logic signed [COEFF_BITS-1:0] coef;
  logic signed [OpW-1:0]        opnd;
  logic [RowW-1:0]              row_word;
  logic                         last_term, pz_pos, div_start, div_done, in_clip, mono_drop;
  logic signed [QuotW-1:0]      div_q;

  assign row_word  = cfg.row[row_r];
  assign last_term = (row_r == 2'd2) && (k_r == 2'd2);
  assign pz_pos    = !acc_r[2][AccW-1] && (acc_r[2] != '0);
  assign div_start = (state_r == B_DIVX && pz_pos) || (state_r == B_DIVY);
  assign pop       = (state_r == B_IDLE) && head_valid;

  always_comb begin
    case (k_r)
      2'd0:    coef = row_word[COEFF_BITS-1:0];
      2'd1:    coef = row_word[2*COEFF_BITS-1:COEFF_BITS];
      default: coef = row_word[3*COEFF_BITS-1:2*COEFF_BITS];
    endcase
    case (k_r)
      2'd0:    opnd = job_r.a;
      2'd1:    opnd = copy_r ? job_r.b_right : job_r.b_left;
      default: opnd = job_r.c;
    endcase
  end

  prp_div #(.NUM_W(AccW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (state_r == B_DIVX ? acc_r[0] : acc_r[1]),
    .den   (acc_r[2]),
    .done  (div_done),
    .quot  (div_q)
  );

  assign in_clip = (qx_r >= QuotW'(cfg.left)) && (qx_r <= QuotW'(cfg.right)) &&
                   (div_q >= QuotW'(cfg.top)) && (div_q <= QuotW'(cfg.bottom));
  assign mono_drop = job_r.mono && nonempty_r && (ly_r > prev_y_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE:  if (head_valid && !head_job.skip) state_nxt = B_MAC;
      B_MAC:   if (last_term) state_nxt = B_ACC;
      B_ACC:   state_nxt = B_DIVX;
      B_DIVX:  state_nxt = pz_pos ? B_WAITX : (copy_r ? B_CHK : B_MAC);
      B_WAITX: if (div_done) state_nxt = B_DIVY;
      B_DIVY:  state_nxt = B_WAITY;
      B_WAITY: if (div_done) state_nxt = copy_r ? B_CHK : B_MAC;
      B_CHK:   state_nxt = (in_ok_r && !mono_drop) ? B_OUT0 : B_IDLE;
      B_OUT0:  if (out_ch.ready) state_nxt = B_OUT1;
      B_OUT1:  if (out_ch.ready) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= B_IDLE;
    else state_r <= state_nxt;
  end

  // datapath
  always_ff @(posedge clk) begin
    if (pop) begin
      job_r   <= head_job;
      in_ok_r <= 1'b1;
      copy_r  <= 1'b0;
      row_r   <= 2'd0;
      k_r     <= 2'd0;
    end
    if (state_r == B_MAC) begin
      prod_r <= coef * opnd;
      prow_r <= row_r;
      if (k_r == 2'd2) begin
        k_r   <= 2'd0;
        row_r <= row_r + 2'd1;
      end else begin
        k_r <= k_r + 2'd1;
      end
      if (row_r == 2'd0 && k_r == 2'd0) begin
        for (int i = 0; i < 3; i++) acc_r[i] <= '0;
      end
    end
    if (pend_r) acc_r[prow_r] <= acc_r[prow_r] + AccW'(prod_r);
    if (state_r == B_DIVX && !pz_pos) begin
      in_ok_r <= 1'b0;
      copy_r  <= 1'b1;
      row_r   <= 2'd0;
      k_r     <= 2'd0;
    end
    if (state_r == B_WAITX && div_done) qx_r <= div_q;
    if (state_r == B_WAITY && div_done) begin
      in_ok_r <= in_ok_r && in_clip;
      copy_r  <= 1'b1;
      row_r   <= 2'd0;
      k_r     <= 2'd0;
      if (copy_r) begin
        rx_r <= sat16(qx_r);
        ry_r <= sat16(div_q);
      end else begin
        lx_r <= sat16(qx_r);
        ly_r <= sat16(div_q);
      end
    end
    if (state_r == B_CHK) begin
      ox_r    <= lx_r;
      oy_r    <= ly_r;
      oside_r <= 1'b0;
    end
    if (state_r == B_OUT0 && out_ch.ready) begin
      ox_r    <= rx_r;
      oy_r    <= ry_r;
      oside_r <= 1'b1;
    end
  end

  // control and polygon state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r     <= 1'b0;
      nonempty_r <= 1'b0;
      prev_y_r   <= '0;
      ovalid_r   <= 1'b0;
    end else begin
      pend_r <= (state_r == B_MAC);
      if (pop && head_job.start) begin
        nonempty_r <= 1'b0;
        prev_y_r   <= '0;
      end
      if (state_r == B_CHK && in_ok_r && !mono_drop) begin
        nonempty_r <= 1'b1;
        prev_y_r   <= ly_r;
      end
      ovalid_r <= (state_nxt == B_OUT0) || (state_nxt == B_OUT1);
    end
  end

  assign out_ch.valid    = ovalid_r;
  assign out_ch.screen_x = ox_r;
  assign out_ch.screen_y = oy_r;
  assign out_ch.side     = oside_r;
  assign out_ch.last     = oside_r;

  a_valid_in_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> (state_r == B_OUT0 || state_r == B_OUT1)) else $error("valid outside output");
  a_right_after_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_OUT0 && out_ch.ready) |=> (ovalid_r && oside_r)) else $error("pair broken");
  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> state_r == B_IDLE) else $error("pop while busy");
  a_emit_sets_poly: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_CHK && state_nxt == B_OUT0) |=> nonempty_r) else $error("state not kept");
endmodule

`default_nettype wire
